[rtl/fraction_reducer_unit_macros.svh]
// Assertion macros shared by the checkers of the fraction reducer.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FRACTION_REDUCER_UNIT_MACROS_SVH
`define FRACTION_REDUCER_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define FRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that forces a consequence at the next clock edge.
`define FRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/frc_pkg.sv]
// Shared types of the fraction reducer.
// No dependencies; imported by the top level.
package frc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_GCD_WAIT,
    ST_NUM_WAIT,
    ST_DEN_WAIT,
    ST_FINISH
  } frc_state_e;

endpackage

[rtl/frc_div.sv]
// Shared restoring divider: unsigned quotient and remainder, one bit per cycle.
// Stand-alone; used by fraction_reducer_unit for Euclid steps and final divisions.
module frc_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = !diff[WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/fraction_reducer_unit.sv]
// Fraction reducer: brings a signed fraction to lowest terms, positive denominator.
// Input request: numer_in_i, denom_in_i on in_valid_i/in_ready_o (valid-ready).
// Result request: numer_out_o, denom_out_o, zero_denom_o on out_valid_o/out_ready_i.
// A zero denominator is taken as one and flags zero_denom_o. A negative denominator
// moves its sign to the numerator. Results too large for the field saturate.
// One request is in work at a time; in_ready_o is high only while the unit is idle.
// The gcd comes from Euclid's remainder loop on one shared bit-serial divider, which
// then also divides numerator and denominator by it. The loop takes one Euclid step
// when the denominator divides the numerator. Each division is started from ST_GCD
// or, for the denominator, from ST_NUM_WAIT, and its result is taken in ST_GCD_WAIT,
// ST_NUM_WAIT or ST_DEN_WAIT; the result then waits in ST_FINISH for the output
// register. The next request is taken while the previous result still waits in the
// output register. If the receiver stalls with a result pending, the unit holds the
// next finished result until the register frees.
// Reset (rst_ni low, asynchronous) empties the output register and idles the unit.
// Depends on frc_pkg and frc_div.
module fraction_reducer_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [WIDTH-1:0] numer_in_i,
  input  logic signed [WIDTH-1:0] denom_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [WIDTH-1:0] numer_out_o,
  output logic        [WIDTH-2:0] denom_out_o,
  output logic                    zero_denom_o
);

  import frc_pkg::*;

  frc_state_e state_q, state_d;

  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] nm_q, nm_d;
  logic [WIDTH-1:0] dm_q, dm_d;
  logic             neg_q, neg_d;
  logic             zf_q, zf_d;

  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] numer_q, numer_d;
  logic [WIDTH-2:0] denom_q, denom_d;
  logic             zero_q, zero_d;

  logic             in_fire;
  logic             out_load;
  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic             div_done;
  logic [WIDTH-1:0] div_quot;
  logic [WIDTH-1:0] div_rem;

  logic             nneg, dneg;
  logic [WIDTH-1:0] nmag, dmag;
  logic [WIDTH-1:0] numer_fmt;
  logic [WIDTH-2:0] denom_fmt;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // magnitudes of the incoming parts; the most negative value maps to 2^(WIDTH-1)
  assign nneg = numer_in_i[WIDTH-1];
  assign dneg = denom_in_i[WIDTH-1];
  assign nmag = nneg ? (~numer_in_i + WIDTH'(1)) : numer_in_i;
  assign dmag = dneg ? (~denom_in_i + WIDTH'(1)) : denom_in_i;

  frc_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_GCD;
      ST_GCD:      state_d = (b_q == '0) ? ST_NUM_WAIT : ST_GCD_WAIT;
      ST_GCD_WAIT: if (div_done) state_d = ST_GCD;
      ST_NUM_WAIT: if (div_done) state_d = ST_DEN_WAIT;
      ST_DEN_WAIT: if (div_done) state_d = ST_FINISH;
      ST_FINISH:   if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_start    = 1'b0;
    div_dividend = a_q;
    div_divisor  = b_q;
    case (state_q)
      ST_GCD: begin
        div_start = 1'b1;
        if (b_q == '0) begin
          div_dividend = nm_q;
          div_divisor  = a_q;
        end
      end
      ST_NUM_WAIT: begin
        div_start    = div_done;
        div_dividend = dm_q;
        div_divisor  = a_q;
      end
      default: ;
    endcase
  end

  // result formatting with saturation
  always_comb begin
    if (nm_q == '0) begin
      numer_fmt = '0;
    end else if (neg_q) begin
      numer_fmt = ~nm_q + WIDTH'(1);
    end else if (nm_q[WIDTH-1]) begin
      numer_fmt = {1'b0, {(WIDTH-1){1'b1}}};
    end else begin
      numer_fmt = nm_q;
    end
    if (nm_q == '0) begin
      denom_fmt = (WIDTH-1)'(1);
    end else if (dm_q[WIDTH-1]) begin
      denom_fmt = '1;
    end else begin
      denom_fmt = dm_q[WIDTH-2:0];
    end
  end

  // datapath
  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    nm_d        = nm_q;
    dm_d        = dm_q;
    neg_d       = neg_q;
    zf_d        = zf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    numer_d     = numer_q;
    denom_d     = denom_q;
    zero_d      = zero_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          nm_d  = nmag;
          zf_d  = (dmag == '0);
          dm_d  = (dmag == '0) ? WIDTH'(1) : dmag;
          neg_d = (nneg != (dneg && (dmag != '0))) && (nmag != '0);
          a_d   = nmag;
          b_d   = (dmag == '0) ? WIDTH'(1) : dmag;
        end
      end
      ST_GCD_WAIT: begin
        if (div_done) begin
          a_d = b_q;
          b_d = div_rem;
        end
      end
      ST_NUM_WAIT: if (div_done) nm_d = div_quot;
      ST_DEN_WAIT: if (div_done) dm_d = div_quot;
      ST_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          numer_d     = numer_fmt;
          denom_d     = denom_fmt;
          zero_d      = zf_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    nm_q    <= nm_d;
    dm_q    <= dm_d;
    neg_q   <= neg_d;
    zf_q    <= zf_d;
    numer_q <= numer_d;
    denom_q <= denom_d;
    zero_q  <= zero_d;
  end

  assign out_valid_o  = out_valid_q;
  assign numer_out_o  = numer_q;
  assign denom_out_o  = denom_q;
  assign zero_denom_o = zero_q;

endmodule

[rtl/frc_checker.sv]
// Port-level checks of the fraction reducer, bound to the top level.
// Depends on fraction_reducer_unit_macros.svh and fraction_reducer_unit.
`include "fraction_reducer_unit_macros.svh"

module frc_checker #(
  parameter int unsigned WIDTH = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic signed [WIDTH-1:0] numer_in_i,
  input logic signed [WIDTH-1:0] denom_in_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [WIDTH-1:0] numer_out_o,
  input logic        [WIDTH-2:0] denom_out_o,
  input logic                    zero_denom_o
);

  `FRC_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready right after request")
  `FRC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(numer_out_o) && $stable(denom_out_o) && $stable(zero_denom_o), "stalled result changed")
  `FRC_ASSERT(a_denom_nonzero, !out_valid_o || (denom_out_o != '0), "zero denominator in result")
  `FRC_ASSERT(a_zero_numer, !out_valid_o || (numer_out_o != '0) || (denom_out_o == (WIDTH-1)'(1)), "zero fraction not 0/1")
  `FRC_ASSERT(a_zero_flag, !out_valid_o || !zero_denom_o || (denom_out_o == (WIDTH-1)'(1)), "flagged result not over one")

endmodule

bind fraction_reducer_unit frc_checker #(.WIDTH(WIDTH)) u_frc_checker (.*);
